// ===== sv/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, codes and constants of the parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  localparam int TRACKS_DEF    = 16;
  localparam int FRAC_BITS_DEF = 16;

  localparam int TRKW  = 4;
  localparam int TICKW = 28;
  localparam int IPW   = 24;
  localparam int SRW   = 18;
  localparam int TPQW  = 15;
  localparam int TMPW  = 24;
  localparam int NUMW  = TMPW + SRW;
  localparam int DENW  = 35;
  localparam int CFGW  = 18;
  localparam int CFGAW = 2;

  localparam logic [SRW-1:0]  SR_RST    = SRW'(44100);
  localparam logic [TPQW-1:0] TPQ_RST   = TPQW'(96);
  localparam logic [TMPW-1:0] TEMPO_RST = TMPW'(500000);
  localparam longint unsigned US_PER_S = 1000000;
  localparam longint unsigned FAST_RATE = 1000;

  localparam logic [CFGAW-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFGAW-1:0] REG_TICKS       = 2'd1;

  localparam logic [2:0] KIND_DELAY   = 3'd0;
  localparam logic [2:0] KIND_CHANNEL = 3'd1;
  localparam logic [2:0] KIND_HEADER  = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  localparam logic [3:0] OP_NOTE_OFF = 4'h8;
  localparam logic [3:0] OP_NOTE_ON  = 4'h9;
  localparam logic [3:0] OP_PROGRAM  = 4'hC;
  localparam logic [3:0] OP_PRESSURE = 4'hD;
  localparam logic [3:0] OP_SYSTEM   = 4'hF;
  localparam logic [7:0] META_STATUS = 8'hFF;
  localparam logic [7:0] META_PREFIX = 8'h20;
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] VEL_RELEASE = 8'h40;
  localparam logic [7:0] PREFIX_RST  = 8'hFF;
  localparam logic [30:0] MAX_FRAMES = 31'h7FFF_FFFF;

  typedef enum logic [2:0] {
    PH_DELAY    = 3'd0,
    PH_LEAD     = 3'd1,
    PH_DATA1    = 3'd2,
    PH_DATA2    = 3'd3,
    PH_METATYPE = 3'd4,
    PH_LEN      = 3'd5,
    PH_PAYLOAD  = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  run_status;
    logic [7:0]  prefix;
    logic [27:0] vlq_acc;
    logic [2:0]  vlq_cnt;
    logic [7:0]  held_status;
    logic [7:0]  held_first;
    logic [27:0] remaining;
    logic [23:0] gather;
  } trk_t;

  localparam trk_t TRK_RST = '{
    phase: PH_DELAY, run_status: 8'h00, prefix: PREFIX_RST, vlq_acc: '0,
    vlq_cnt: '0, held_status: 8'h00, held_first: 8'h00, remaining: '0, gather: '0
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  event_track;
    logic [7:0]  status_code;
    logic [7:0]  channel;
    logic [7:0]  data_a;
    logic [7:0]  data_b;
    logic [27:0] payload_length;
    logic [7:0]  payload_value;
    logic [30:0] delay_frames;
  } res_t;

  typedef struct packed {
    logic accept;
    logic mem_rd;
    logic exec;
    logic mul;
    logic sat;
    logic load_out;
    logic div_start;
  } cmd_t;

  typedef struct packed {
    logic recompute_req;
    logic div_busy;
    logic exec_has;
    logic exec_delay;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/mtep_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel
// One track byte per word, with its track number and chunk-end mark.
// ----------------------------------------------------------------------------
interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] track_index;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, track_index, data_byte, chunk_end, input ready);
  modport sink (input valid, track_index, data_byte, chunk_end, output ready);
endinterface

// ===== sv/mtep_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// One parsed result per word.
// ----------------------------------------------------------------------------
interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  event_track;
  logic [7:0]  status_code;
  logic [7:0]  channel;
  logic [7:0]  data_a;
  logic [7:0]  data_b;
  logic [27:0] payload_length;
  logic [7:0]  payload_value;
  logic [30:0] delay_frames;

  modport source (output valid, kind, event_track, status_code, channel, data_a, data_b,
                  payload_length, payload_value, delay_frames, input ready);
  modport sink (input valid, kind, event_track, status_code, channel, data_a, data_b,
                payload_length, payload_value, delay_frames, output ready);
endinterface

// ===== sv/mtep_div.sv =====
// ----------------------------------------------------------------------------
// Frames-per-tick divider
// Restoring long division of (tempo * rate) << FRAC_BITS by the tick scale,
// one quotient bit per cycle, with the floor of 1.0 and the zero fallback.
// ----------------------------------------------------------------------------
module mtep_div import mtep_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [NUMW-1:0]          num,
  input  logic [DENW-1:0]          den,
  output logic                     busy,
  output logic                     done,
  output logic [IPW+FRAC_BITS-1:0] quo
);

  localparam int FW = IPW + FRAC_BITS;
  localparam int NW = NUMW + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic [FW-1:0] FPT_ONE  = FW'(1) << FRAC_BITS;
  localparam logic [FW-1:0] FPT_FAST = FW'(FAST_RATE) << FRAC_BITS;

  logic [NW-1:0]   dvd_r;
  logic [DENW-1:0] den_r;
  logic [DENW:0]   rem_r;
  logic [FW-1:0]   quo_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;
  logic            done_r;
  logic            zero_r;
  logic [DENW:0]   trial;
  logic            fits;

  assign trial = {rem_r[DENW-1:0], dvd_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (zero_r || cnt_r == CW'(1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= {num, {FRAC_BITS{1'b0}}};
      den_r  <= den;
      rem_r  <= '0;
      quo_r  <= '0;
      cnt_r  <= CW'(NW);
      zero_r <= (num == '0) || (den == '0);
    end else if (busy_r) begin
      if (zero_r) begin
        quo_r <= FPT_FAST;
      end else begin
        rem_r <= fits ? (trial - {1'b0, den_r}) : trial;
        quo_r <= {quo_r[FW-2:0], fits};
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = (quo_r < FPT_ONE) ? FPT_ONE : quo_r;

endmodule

// ===== sv/mtep_ctrl.sv =====
// ----------------------------------------------------------------------------
// Parser controller
// Sequences read, parse, delay scaling, result hand-off and rate recompute.
// ----------------------------------------------------------------------------
module mtep_ctrl import mtep_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_EXEC = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_SAT  = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_DIV  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (sts.recompute_req) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.exec_has) begin
          state_nxt = S_IDLE;
        end else if (sts.exec_delay) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_DIV: begin
        // A register write during the recompute restarts it with the new value.
        if (sts.recompute_req) begin
          cmd.div_start = 1'b1;
        end else if (!sts.div_busy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/mtep_dpath.sv =====
// ----------------------------------------------------------------------------
// Parser datapath
// Per-track state memory, byte parser, delay scaling and result register.
// ----------------------------------------------------------------------------
module mtep_dpath import mtep_pkg::*; #(
  parameter int TRACKS    = TRACKS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFGAW-1:0]  cfg_idx,
  input  logic [CFGW-1:0]   cfg_data,
  input  logic [3:0]        in_track,
  input  logic [7:0]        in_byte,
  input  logic              in_end,
  input  cmd_t              cmd,
  output sts_t              sts,
  mtep_out_if.source        out_ch
);

  localparam int AW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int FW = IPW + FRAC_BITS;
  localparam int TOTW = TICKW + IPW + 1;
  localparam longint unsigned FPT_RST_W =
    ((longint'(TEMPO_RST) * longint'(SR_RST)) << FRAC_BITS) /
    (US_PER_S * longint'(TPQ_RST));

  logic [SRW-1:0]  sr_r;
  logic [TPQW-1:0] tpq_r;
  logic [TMPW-1:0] tempo_r;
  logic [FW-1:0]   fpt_r;
  logic            err_r;
  logic            pend_r;

  logic [3:0] trk_r;
  logic [7:0] byte_r;
  logic       end_r;

  trk_t            mem [TRACKS];
  logic [TRACKS-1:0] vld_r;
  trk_t            rd_r;
  logic            rd_vld_r;
  logic [AW-1:0]   addr;
  logic            in_range;
  logic            wr;
  trk_t            cur;
  trk_t            ns;

  res_t             xres;
  res_t             res_r;
  logic             x_has, x_delay, x_fail, x_done, x_tempo_we;
  logic [TMPW-1:0]  x_tempo;

  logic [27:0] acc0, vlq_acc_n;
  logic [2:0]  vlq_cnt_n;
  logic        vlq_last, vlq_over;
  logic [7:0]  lead;
  logic        consumed;
  logic [23:0] gather_n;

  logic [TICKW-1:0]           ticks_r;
  logic [TICKW+IPW-1:0]       prod_ip_r;
  logic [TICKW+FRAC_BITS-1:0] prod_fp_r;
  logic [TOTW-1:0]            total;

  logic [NUMW-1:0] div_num;
  logic [DENW-1:0] div_den;
  logic            div_busy, div_done;
  logic [FW-1:0]   div_quo;

  assign addr     = AW'(trk_r);
  assign in_range = int'(trk_r) < TRACKS;
  assign cur      = rd_vld_r ? rd_r : TRK_RST;
  assign wr       = cmd.exec && !err_r && in_range;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      trk_r  <= in_track;
      byte_r <= in_byte;
      end_r  <= in_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_r <= mem[addr];
    end
    if (wr) begin
      mem[addr] <= ns;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.mem_rd) begin
        rd_vld_r <= vld_r[addr];
      end
      if (wr) begin
        vld_r[addr] <= 1'b1;
      end
    end
  end

  // Shared variable-length quantity step for delays and meta lengths.
  always_comb begin
    acc0      = (cur.vlq_cnt == 3'd0) ? 28'd0 : cur.vlq_acc;
    vlq_acc_n = {acc0[20:0], byte_r[6:0]};
    vlq_cnt_n = cur.vlq_cnt + 3'd1;
    vlq_last  = !byte_r[7];
    vlq_over  = !vlq_last && (vlq_cnt_n >= 3'd4);
  end

  always_comb begin
    ns         = cur;
    xres       = '0;
    xres.event_track = trk_r;
    x_has      = 1'b0;
    x_delay    = 1'b0;
    x_fail     = 1'b0;
    x_done     = 1'b0;
    x_tempo_we = 1'b0;
    x_tempo    = cur.gather;
    lead       = byte_r;
    consumed   = 1'b1;
    gather_n   = {cur.gather[15:0], byte_r};
    case (cur.phase)
      PH_DELAY: begin
        ns.vlq_acc = vlq_acc_n;
        ns.vlq_cnt = vlq_last ? 3'd0 : vlq_cnt_n;
        if (vlq_over) begin
          x_fail = 1'b1;
        end else if (vlq_last) begin
          xres.kind = KIND_DELAY;
          x_has     = 1'b1;
          x_delay   = 1'b1;
          x_done    = 1'b1;
          ns.phase  = PH_LEAD;
        end
      end
      PH_LEAD: begin
        if (byte_r[7]) begin
          lead     = byte_r;
          consumed = 1'b1;
        end else begin
          lead     = cur.run_status;
          consumed = 1'b0;
        end
        if (!byte_r[7] && cur.run_status == 8'h00) begin
          x_fail = 1'b1;
        end else begin
          ns.run_status  = lead;
          ns.held_status = lead;
          if (lead[7:4] == OP_SYSTEM) begin
            ns.run_status = 8'h00;
            ns.held_first = 8'h00;
            ns.vlq_cnt    = 3'd0;
            ns.phase      = (lead == META_STATUS) ? PH_METATYPE : PH_LEN;
          end else if (consumed) begin
            ns.phase = PH_DATA1;
          end else if (lead[7:4] inside {OP_PROGRAM, OP_PRESSURE}) begin
            xres.kind        = KIND_CHANNEL;
            xres.status_code = {lead[7:4], 4'h0};
            xres.channel     = {4'h0, lead[3:0]};
            xres.data_a      = byte_r;
            x_has            = 1'b1;
            x_done           = 1'b1;
            ns.phase         = PH_DELAY;
          end else begin
            ns.held_first = byte_r;
            ns.phase      = PH_DATA2;
          end
        end
      end
      PH_DATA1: begin
        if (cur.held_status[7:4] inside {OP_PROGRAM, OP_PRESSURE}) begin
          xres.kind        = KIND_CHANNEL;
          xres.status_code = {cur.held_status[7:4], 4'h0};
          xres.channel     = {4'h0, cur.held_status[3:0]};
          xres.data_a      = byte_r;
          x_has            = 1'b1;
          x_done           = 1'b1;
          ns.phase         = PH_DELAY;
        end else begin
          ns.held_first = byte_r;
          ns.phase      = PH_DATA2;
        end
      end
      PH_DATA2: begin
        xres.kind        = KIND_CHANNEL;
        xres.status_code = {cur.held_status[7:4], 4'h0};
        xres.channel     = {4'h0, cur.held_status[3:0]};
        xres.data_a      = cur.held_first;
        xres.data_b      = byte_r;
        // A note-on with zero velocity is reported as a release.
        if (cur.held_status[7:4] == OP_NOTE_ON && byte_r == 8'h00) begin
          xres.status_code = {OP_NOTE_OFF, 4'h0};
          xres.data_b      = VEL_RELEASE;
        end
        x_has    = 1'b1;
        x_done   = 1'b1;
        ns.phase = PH_DELAY;
      end
      PH_METATYPE: begin
        ns.held_first = byte_r;
        ns.vlq_cnt    = 3'd0;
        ns.phase      = PH_LEN;
      end
      PH_LEN: begin
        ns.vlq_acc = vlq_acc_n;
        ns.vlq_cnt = vlq_last ? 3'd0 : vlq_cnt_n;
        if (vlq_over) begin
          x_fail = 1'b1;
        end else if (vlq_last) begin
          xres.kind           = KIND_HEADER;
          xres.status_code    = cur.held_status;
          xres.channel        = cur.prefix;
          xres.data_a         = cur.held_first;
          xres.payload_length = vlq_acc_n;
          x_has               = 1'b1;
          ns.remaining        = vlq_acc_n;
          if (vlq_acc_n == 28'd0) begin
            x_done   = 1'b1;
            ns.phase = PH_DELAY;
          end else begin
            ns.phase  = PH_PAYLOAD;
            ns.gather = 24'd0;
          end
        end
      end
      PH_PAYLOAD: begin
        xres.kind          = KIND_PAYLOAD;
        xres.payload_value = byte_r;
        x_has              = 1'b1;
        if (cur.held_status == META_STATUS) begin
          if (cur.held_first == META_PREFIX && cur.vlq_cnt == 3'd0) begin
            ns.prefix = byte_r;
          end
          if (cur.held_first == META_TEMPO && cur.vlq_cnt < 3'd3) begin
            ns.gather = gather_n;
            if (cur.vlq_cnt == 3'd2) begin
              x_tempo_we = 1'b1;
              x_tempo    = gather_n;
            end
          end
          if (cur.vlq_cnt < 3'd3) begin
            ns.vlq_cnt = cur.vlq_cnt + 3'd1;
          end
        end
        ns.remaining = cur.remaining - 28'd1;
        if (cur.remaining == 28'd1) begin
          ns.vlq_cnt = 3'd0;
          ns.phase   = PH_DELAY;
          x_done     = 1'b1;
        end
      end
      default: begin
        ns.phase   = PH_DELAY;
        ns.vlq_cnt = 3'd0;
      end
    endcase

    // Chunk end is only legal on a byte that completes a delay or an event.
    if (!x_fail && end_r) begin
      if (x_done) begin
        ns = TRK_RST;
      end else begin
        x_fail = 1'b1;
      end
    end
    if (x_fail) begin
      xres             = '0;
      xres.kind        = KIND_ERROR;
      xres.event_track = trk_r;
      x_has            = 1'b1;
      x_delay          = 1'b0;
      x_tempo_we       = 1'b0;
    end
    if (err_r) begin
      xres             = '0;
      xres.kind        = KIND_ERROR;
      xres.event_track = trk_r;
      x_has            = 1'b1;
      x_delay          = 1'b0;
      x_fail           = 1'b0;
      x_tempo_we       = 1'b0;
    end else if (!in_range) begin
      x_has      = 1'b0;
      x_delay    = 1'b0;
      x_fail     = 1'b0;
      x_tempo_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r    <= SR_RST;
      tpq_r   <= TPQ_RST;
      tempo_r <= TEMPO_RST;
      fpt_r   <= FW'(FPT_RST_W);
      err_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == REG_SAMPLE_RATE) begin
        sr_r <= cfg_data[SRW-1:0];
      end
      if (cfg_we && cfg_idx == REG_TICKS) begin
        tpq_r <= cfg_data[TPQW-1:0];
      end
      if (cmd.exec && x_tempo_we) begin
        tempo_r <= x_tempo;
      end
      if (cmd.exec && x_fail) begin
        err_r <= 1'b1;
      end
      if ((cfg_we && (cfg_idx == REG_SAMPLE_RATE || cfg_idx == REG_TICKS)) ||
          (cmd.exec && x_tempo_we)) begin
        pend_r <= 1'b1;
      end else if (cmd.div_start) begin
        pend_r <= 1'b0;
      end
      if (div_done) begin
        fpt_r <= div_quo;
      end
    end
  end

  assign div_num = NUMW'(tempo_r) * NUMW'(sr_r);
  assign div_den = DENW'(US_PER_S) * DENW'(tpq_r);

  mtep_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Delay scaling: integer and fraction products, then sum and saturate.
  assign total = TOTW'(prod_ip_r) + TOTW'(prod_fp_r >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r   <= xres;
      ticks_r <= vlq_acc_n;
    end else if (cmd.sat) begin
      res_r.delay_frames <= (total > TOTW'(MAX_FRAMES)) ? MAX_FRAMES : total[30:0];
    end
    if (cmd.mul) begin
      prod_ip_r <= (TICKW+IPW)'(ticks_r) * (TICKW+IPW)'(fpt_r[FW-1:FRAC_BITS]);
      prod_fp_r <= (TICKW+FRAC_BITS)'(ticks_r) * (TICKW+FRAC_BITS)'(fpt_r[FRAC_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch.kind           <= res_r.kind;
      out_ch.event_track    <= res_r.event_track;
      out_ch.status_code    <= res_r.status_code;
      out_ch.channel        <= res_r.channel;
      out_ch.data_a         <= res_r.data_a;
      out_ch.data_b         <= res_r.data_b;
      out_ch.payload_length <= res_r.payload_length;
      out_ch.payload_value  <= res_r.payload_value;
      out_ch.delay_frames   <= res_r.delay_frames;
    end
  end

  assign sts.recompute_req = pend_r;
  assign sts.div_busy      = div_busy;
  assign sts.exec_has      = x_has;
  assign sts.exec_delay    = x_delay;
  assign sts.out_free      = !out_ch.valid || out_ch.ready;

endmodule

// ===== sv/midi_track_event_parser_top.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser
// Cuts tagged MTrk byte streams into delays, channel events and meta data.
// ----------------------------------------------------------------------------
// One byte word is taken at a time. A byte that gives no result passes the
// read and parse states, one with a result also the emit state, and a delay
// also the multiply and saturate states, around the single-ported per-track
// state memory. A finished result waits in the output register while the next
// byte is taken. A register write or a completed Set Tempo starts a bit-serial
// recompute of frames per tick that holds the input off until it is done, and
// ends early with the fallback when the tempo, the rate or the division is zero.
// There is no clearing pass after reset.
module midi_track_event_parser_top import mtep_pkg::*; #(
  parameter int TRACKS    = TRACKS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFGAW-1:0] cfg_idx,
  input  logic [CFGW-1:0]  cfg_data,
  mtep_in_if.sink          in_ch,
  mtep_out_if.source       out_ch
);

  cmd_t cmd;
  sts_t sts;

  mtep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtep_dpath #(.TRACKS(TRACKS), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_track (in_ch.track_index),
    .in_byte  (in_ch.data_byte),
    .in_end   (in_ch.chunk_end),
    .cmd      (cmd),
    .sts      (sts),
    .out_ch   (out_ch)
  );

`ifndef SYNTH
  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken on two consecutive cycles");

  a_no_word_during_recompute: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_busy |-> !in_ch.ready)
    else $error("input taken while frames per tick is recomputed");

  a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_idx == REG_SAMPLE_RATE || cfg_idx == REG_TICKS)) |=> !in_ch.ready)
    else $error("input taken before recompute after a register write");
`endif

endmodule
